// File: rtl/srle_pkg.sv
// srle_pkg: types and constants shared by the sprite line run-length decoder
// used by srle_cfg, srle_core and sprite_line_rle_decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package srle_pkg;

  localparam int unsigned DIM_W   = 13;  // width of the size registers and position state
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 2;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_COUNT = 2'd2;

  // coding mode codes
  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAIR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PACKED = 2'd2;

  localparam logic [BYTE_W-1:0] PAIR_LIT_MARK = 8'd255;  // value byte that opens a literal
  localparam logic [2:0]        PACK_LIT_TOP  = 3'b111;  // top bits that open a literal

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_LEN  = 2'd1,
    PH_LIT  = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIM_W-1:0]  width;  // already limited to the size cap
    logic [DIM_W-1:0]  count;  // already limited to the size cap
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [CNT_W-1:0]  run_count;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              line_end;
    logic              image_end;
    logic              overrun;
  } run_t;

endpackage

`default_nettype wire

// File: rtl/sprite_line_rle_decoder.sv
// sprite_line_rle_decoder: an accepted item is held in the input register, then decoded
// into the result register; one item per cycle sustained while the result register is
// free or being emptied, the decode state being updated in the same cycle as the result
// an item that gives no result leaves the result register untouched
// reset (async, active low) clears decode state, config to raw / 1x1, both registers empty
// depends on srle_pkg, srle_cfg, srle_core
`timescale 1ns / 1ps
`default_nettype none

module sprite_line_rle_decoder #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [srle_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [srle_pkg::DIM_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          first_i,
  input  wire logic [srle_pkg::BYTE_W-1:0]   code_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [srle_pkg::BYTE_W-1:0]        pixel_value_o,
  output logic [srle_pkg::CNT_W-1:0]         run_count_o,
  output logic [srle_pkg::ROW_W-1:0]         row_o,
  output logic [srle_pkg::COL_W-1:0]         column_o,
  output logic                               line_end_o,
  output logic                               image_end_o,
  output logic                               overrun_o
);
  import srle_pkg::*;

  cfg_t               cfg;
  logic               in_valid_q;
  logic               first_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               advance;
  logic               run_valid;
  run_t               run;
  logic               out_valid_q;
  run_t               out_q;

  srle_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the held item moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      first_q <= first_i;
      byte_q  <= code_byte_i;
    end
  end

  srle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .first_i     (first_q),
    .code_byte_i (byte_q),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && run_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && run_valid) begin
      out_q <= run;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_q.pixel_value;
  assign run_count_o   = out_q.run_count;
  assign row_o         = out_q.row;
  assign column_o      = out_q.column;
  assign line_end_o    = out_q.line_end;
  assign image_end_o   = out_q.image_end;
  assign overrun_o     = out_q.overrun;

endmodule

`default_nettype wire

// File: rtl/srle_cfg.sv
// srle_cfg: configuration registers of the decoder, with the size cap applied
// depends on srle_pkg
`timescale 1ns / 1ps
`default_nettype none

module srle_cfg #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [srle_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [srle_pkg::DIM_W-1:0]   cfg_data_i,
  output srle_pkg::cfg_t                    cfg_o
);
  import srle_pkg::*;

  // a cap above what the register can hold never bites
  localparam int unsigned CapInt = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
  localparam logic [DIM_W-1:0] DimCap = DIM_W'(CapInt);

  logic [MODE_W-1:0] mode_q;
  logic [DIM_W-1:0]  width_q;
  logic [DIM_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RAW;
      width_q <= DIM_W'(1);
      count_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        REG_WIDTH: width_q <= cfg_data_i;
        REG_COUNT: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.mode  = mode_q;
  assign cfg_o.width = (width_q > DimCap) ? DimCap : width_q;
  assign cfg_o.count = (count_q > DimCap) ? DimCap : count_q;

endmodule

`default_nettype wire

// File: rtl/srle_core.sv
// srle_core: decode state (phase, held value, literal count, row, column) and
// the single-pass byte decode; depends on srle_pkg
`timescale 1ns / 1ps
`default_nettype none

module srle_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  srle_pkg::cfg_t                     cfg_i,
  input  wire logic                          step_i,
  input  wire logic                          first_i,
  input  wire logic [srle_pkg::BYTE_W-1:0]   code_byte_i,
  output logic                               run_valid_o,
  output srle_pkg::run_t                     run_o
);
  import srle_pkg::*;

  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]   lit_q, lit_d;
  logic [DIM_W-1:0]   col_q, col_d;
  logic [DIM_W-1:0]   row_q, row_d;

  phase_e             phase_base;
  logic [CNT_W-1:0]   lit_base;
  logic [CNT_W-1:0]   lit_dec;
  logic [DIM_W-1:0]   col_base;
  logic [DIM_W-1:0]   row_base;
  logic               done;
  logic               emit_go;
  logic               lit_byte;
  logic [BYTE_W-1:0]  emit_val;
  logic [CNT_W-1:0]   emit_cnt;
  logic [CNT_W-1:0]   pair_len;
  logic [CNT_W-1:0]   pack_len;
  logic [DIM_W:0]     end_col;
  logic [DIM_W:0]     row_inc;
  logic               le;
  logic               ov;
  logic               ie;

  always_comb begin
    // a first item restarts the sprite before the byte is decoded
    phase_base = first_i ? PH_HEAD : phase_q;
    lit_base   = first_i ? '0 : lit_q;
    col_base   = first_i ? '0 : col_q;
    row_base   = first_i ? '0 : row_q;
    done       = (row_base >= cfg_i.count);
    lit_dec    = lit_base - CNT_W'(1);
    pair_len   = {1'b0, code_byte_i} + CNT_W'(1);
    pack_len   = {4'b0, code_byte_i[4:0]} + CNT_W'(1);

    phase_d  = phase_base;
    lit_d    = lit_base;
    held_d   = held_q;
    emit_go  = 1'b0;
    lit_byte = 1'b0;
    emit_val = code_byte_i;
    emit_cnt = CNT_W'(1);

    if (!done) begin
      case (cfg_i.mode)
        MODE_PAIR: begin
          case (phase_base)
            PH_LIT: begin
              emit_go  = 1'b1;
              lit_byte = 1'b1;
            end
            PH_SKIP: begin
              lit_d = lit_dec;
              if (lit_dec == '0) phase_d = PH_HEAD;
            end
            PH_HEAD: begin
              held_d  = code_byte_i;
              phase_d = PH_LEN;
            end
            default: begin
              if (held_q == PAIR_LIT_MARK) begin
                lit_d   = pair_len;
                phase_d = PH_LIT;
              end else begin
                phase_d  = PH_HEAD;
                emit_go  = 1'b1;
                emit_val = held_q;
                emit_cnt = pair_len;
              end
            end
          endcase
        end
        MODE_PACKED: begin
          case (phase_base)
            PH_LIT: begin
              emit_go  = 1'b1;
              lit_byte = 1'b1;
            end
            PH_SKIP: begin
              lit_d = lit_dec;
              if (lit_dec == '0) phase_d = PH_HEAD;
            end
            default: begin
              // a length phase left over from pair mode counts as a header
              if (code_byte_i[7:5] == PACK_LIT_TOP) begin
                lit_d   = pack_len;
                phase_d = PH_LIT;
              end else begin
                phase_d  = PH_HEAD;
                emit_go  = 1'b1;
                emit_val = {5'b0, code_byte_i[7:5]};
                emit_cnt = pack_len;
              end
            end
          endcase
        end
        default: begin
          phase_d = PH_HEAD;
          lit_d   = '0;
          emit_go = 1'b1;
        end
      endcase
    end

    end_col = {1'b0, col_base} + {{(DIM_W + 1 - CNT_W){1'b0}}, emit_cnt};
    row_inc = {1'b0, row_base} + (DIM_W + 1)'(1);
    le      = (end_col >= {1'b0, cfg_i.width});
    ov      = (end_col > {1'b0, cfg_i.width});
    ie      = le && (row_inc >= {1'b0, cfg_i.count});

    col_d = col_base;
    row_d = row_base;
    if (emit_go) begin
      if (le) begin
        col_d = '0;
        row_d = row_inc[DIM_W-1:0];
      end else begin
        col_d = end_col[DIM_W-1:0];
      end
    end

    // literal bytes past the row end are swallowed
    if (lit_byte) begin
      lit_d = lit_dec;
      if (lit_dec == '0) begin
        phase_d = PH_HEAD;
      end else if (le) begin
        ov      = 1'b1;
        phase_d = PH_SKIP;
      end
    end

    run_valid_o       = emit_go;
    run_o.pixel_value = emit_val;
    run_o.run_count   = emit_cnt;
    run_o.row         = row_base[ROW_W-1:0];
    run_o.column      = col_base[COL_W-1:0];
    run_o.line_end    = le;
    run_o.image_end   = ie;
    run_o.overrun     = ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      held_q  <= '0;
      lit_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      lit_q   <= lit_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

`default_nettype wire
